@@ sv/encpid_pkg.sv @@
// Shared types and constants for the encoder speed controller.
// Used by every encpid_* module and the top level; no dependencies.
`default_nettype none

package encpid_pkg;

    // Register indexes of the configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SETPOINT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT    = 3'd5;

    localparam logic [14:0] DRIVE_LIMIT_RESET = 15'd2000;

    // Bound on one PID increment.
    localparam logic signed [8:0] STEP_MAX = 9'sd200;
    localparam logic signed [8:0] STEP_MIN = -9'sd200;

    localparam logic signed [15:0] SPEED_MAX = 16'sh7fff;
    localparam logic signed [15:0] SPEED_MIN = 16'sh8000;

    // Error differences and PID term widths.
    localparam int D1_W   = 18;
    localparam int D2_W   = 19;
    localparam int PROD_W = 36;
    localparam int SUM_W  = PROD_W + 2;

    typedef struct packed {
        logic [15:0] encoder_count;
        logic        moving_forward;
    } enc_in_t;

    typedef struct packed {
        logic [14:0]        duty_forward;
        logic [14:0]        duty_reverse;
        logic signed [15:0] measured_speed;
    } enc_out_t;

    // Load enables of the pipeline stages.
    typedef struct packed {
        logic accept;
        logic s1_load;
        logic s2_load;
        logic s3_load;
        logic s4_load;
        logic s5_load;
    } pipe_ctl_t;

    typedef struct packed {
        logic signed [15:0]     speed;
        logic signed [15:0]     e0;
        logic signed [D1_W-1:0] d1;
        logic signed [D2_W-1:0] d2;
    } err_stage_t;

    typedef struct packed {
        logic signed [15:0]       speed;
        logic signed [PROD_W-1:0] p_term;
        logic signed [PROD_W-1:0] i_term;
        logic signed [PROD_W-1:0] d_term;
    } prod_stage_t;

    // Saturate a 17-bit signed value to 16 bits.
    function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v[16] != v[15])
        begin
            r = v[16] ? SPEED_MIN : SPEED_MAX;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/encoder_incremental_pid_speed.sv @@
// Top level of the encoder speed controller: handshakes, registers, stage control.
// Depends on encpid_pkg, encpid_error, encpid_mult and encpid_drive.
//
//   channel   signals                               payload
//   in        in_valid / in_ready                   in_data (enc_in_t)
//   out       out_valid / out_ready                 out_data (enc_out_t)
//   cfg       cfg_write_en, cfg_index               cfg_wdata (16 bits)
//
// One request is taken per cycle while in_ready is high; its result leaves via out_data.
// The drive accumulator loop closes within the output stage, so ticks stream back to back.
// A request taken while control is disabled only updates the last encoder count.
// Reset clears the stage valids, the encoder and error history and the accumulator,
// and returns the registers to their reset values. When out_ready is low the stages
// fill up behind the output register and in_ready drops once all five hold a request.
`default_nettype none

module encoder_incremental_pid_speed
    import encpid_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire enc_in_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output enc_out_t                   out_data,
    input  wire logic                  cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic               control_enable_reg;
    logic signed [15:0] speed_setpoint_reg;
    logic [15:0]        gain_prop_reg;
    logic [15:0]        gain_integ_reg;
    logic [15:0]        gain_deriv_reg;
    logic [14:0]        drive_limit_reg;

    // Valid bit of stages one to five; the last is the output register.
    logic [4:0]  stage_valid_reg;
    logic [4:0]  stage_valid_next;
    logic [4:0]  stage_ready;
    pipe_ctl_t   ctl;
    err_stage_t  err_stage;
    prod_stage_t prod_stage;

    always_comb
    begin
        stage_ready[4] = !stage_valid_reg[4] || out_ready;
        stage_ready[3] = !stage_valid_reg[3] || stage_ready[4];
        stage_ready[2] = !stage_valid_reg[2] || stage_ready[3];
        stage_ready[1] = !stage_valid_reg[1] || stage_ready[2];
        stage_ready[0] = !stage_valid_reg[0] || stage_ready[1];

        ctl.accept  = in_valid && stage_ready[0];
        ctl.s1_load = ctl.accept && control_enable_reg;
        ctl.s2_load = stage_valid_reg[0] && stage_ready[1];
        ctl.s3_load = stage_valid_reg[1] && stage_ready[2];
        ctl.s4_load = stage_valid_reg[2] && stage_ready[3];
        ctl.s5_load = stage_valid_reg[3] && stage_ready[4];

        stage_valid_next[0] = ctl.s1_load || (stage_valid_reg[0] && !ctl.s2_load);
        stage_valid_next[1] = ctl.s2_load || (stage_valid_reg[1] && !ctl.s3_load);
        stage_valid_next[2] = ctl.s3_load || (stage_valid_reg[2] && !ctl.s4_load);
        stage_valid_next[3] = ctl.s4_load || (stage_valid_reg[3] && !ctl.s5_load);
        stage_valid_next[4] = ctl.s5_load || (stage_valid_reg[4] && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_enable_reg <= 1'b0;
            speed_setpoint_reg <= '0;
            gain_prop_reg      <= '0;
            gain_integ_reg     <= '0;
            gain_deriv_reg     <= '0;
            drive_limit_reg    <= DRIVE_LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_CONTROL_ENABLE: control_enable_reg <= cfg_wdata[0];
                CFG_SPEED_SETPOINT: speed_setpoint_reg <= $signed(cfg_wdata);
                CFG_GAIN_PROP:      gain_prop_reg      <= cfg_wdata;
                CFG_GAIN_INTEG:     gain_integ_reg     <= cfg_wdata;
                CFG_GAIN_DERIV:     gain_deriv_reg     <= cfg_wdata;
                CFG_DRIVE_LIMIT:    drive_limit_reg    <= cfg_wdata[14:0];
                default:            ;
            endcase
        end
    end

    encpid_error u_error (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .in_item        (in_data),
        .speed_setpoint (speed_setpoint_reg),
        .err_stage      (err_stage)
    );

    encpid_mult u_mult (
        .clk        (clk),
        .ctl        (ctl),
        .err_stage  (err_stage),
        .gain_prop  (gain_prop_reg),
        .gain_integ (gain_integ_reg),
        .gain_deriv (gain_deriv_reg),
        .prod_stage (prod_stage)
    );

    encpid_drive u_drive (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .prod_stage  (prod_stage),
        .drive_limit (drive_limit_reg),
        .out_item    (out_data)
    );

    assign in_ready  = stage_ready[0];
    assign out_valid = stage_valid_reg[4];

    // Input back-pressure only when every stage is full and the output is held.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (stage_valid_reg == 5'b11111) && !out_ready)
        else $error("input stalled while the pipeline has room");

    // A new result can only come from a request in the stage before the output.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(stage_valid_reg[3]))
        else $error("result appeared without a request in the increment stage");

    // At most one of the two duties carries drive.
    a_one_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.duty_forward == 15'd1 || out_data.duty_reverse == 15'd1))
        else $error("both duties active at once");

endmodule

`default_nettype wire

@@ sv/encpid_error.sv @@
// Speed measurement and error history stages of the speed controller.
// Depends on encpid_pkg.
`default_nettype none

module encpid_error
    import encpid_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pipe_ctl_t          ctl,
    input  wire enc_in_t            in_item,
    input  wire logic signed [15:0] speed_setpoint,
    output err_stage_t              err_stage
);

    logic [15:0]        last_count_reg;
    logic signed [15:0] speed_reg;
    logic signed [15:0] error_prev_reg;
    logic signed [15:0] error_prev2_reg;
    err_stage_t         err_reg;

    logic [15:0]        delta;
    logic signed [15:0] speed_next;
    logic signed [15:0] e0;
    err_stage_t         err_next;

    // The count change wraps modulo 2^16; the pin gives it a sign.
    always_comb
    begin
        delta = in_item.encoder_count - last_count_reg;
        if (in_item.moving_forward)
        begin
            speed_next = delta[15] ? SPEED_MAX : $signed(delta);
        end
        else
        begin
            speed_next = delta[15] ? SPEED_MIN : -$signed({1'b0, delta[14:0]});
        end
    end

    always_comb
    begin
        e0 = sat17(17'(speed_setpoint) - 17'(speed_reg));
        err_next.speed = speed_reg;
        err_next.e0    = e0;
        err_next.d1    = D1_W'(e0) - D1_W'(error_prev_reg);
        err_next.d2    = D2_W'(e0) - (D2_W'(error_prev_reg) <<< 1) + D2_W'(error_prev2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg  <= '0;
            error_prev_reg  <= '0;
            error_prev2_reg <= '0;
        end
        else
        begin
            if (ctl.accept)
            begin
                last_count_reg <= in_item.encoder_count;
            end
            if (ctl.s2_load)
            begin
                error_prev_reg  <= e0;
                error_prev2_reg <= error_prev_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            speed_reg <= speed_next;
        end
        if (ctl.s2_load)
        begin
            err_reg <= err_next;
        end
    end

    assign err_stage = err_reg;

endmodule

`default_nettype wire

@@ sv/encpid_mult.sv @@
// Gain multiply stage: the three PID terms, each registered.
// Depends on encpid_pkg.
`default_nettype none

module encpid_mult
    import encpid_pkg::*;
(
    input  wire logic        clk,
    input  wire pipe_ctl_t   ctl,
    input  wire err_stage_t  err_stage,
    input  wire logic [15:0] gain_prop,
    input  wire logic [15:0] gain_integ,
    input  wire logic [15:0] gain_deriv,
    output prod_stage_t      prod_stage
);

    logic signed [16:0]       gp_s;
    logic signed [16:0]       gi_s;
    logic signed [16:0]       gd_s;
    logic signed [PROD_W-1:0] p_full;
    logic signed [PROD_W-1:0] i_full;
    logic signed [PROD_W-1:0] d_full;
    prod_stage_t              prod_reg;

    assign gp_s = $signed({1'b0, gain_prop});
    assign gi_s = $signed({1'b0, gain_integ});
    assign gd_s = $signed({1'b0, gain_deriv});

    assign p_full = PROD_W'(gp_s) * PROD_W'(err_stage.d1);
    assign i_full = PROD_W'(gi_s) * PROD_W'(err_stage.e0);
    assign d_full = PROD_W'(gd_s) * PROD_W'(err_stage.d2);

    always_ff @(posedge clk)
    begin
        if (ctl.s3_load)
        begin
            prod_reg.speed  <= err_stage.speed;
            prod_reg.p_term <= p_full;
            prod_reg.i_term <= i_full;
            prod_reg.d_term <= d_full;
        end
    end

    assign prod_stage = prod_reg;

endmodule

`default_nettype wire

@@ sv/encpid_drive.sv @@
// Increment clamp, drive accumulator and duty output register.
// Depends on encpid_pkg.
`default_nettype none

module encpid_drive
    import encpid_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pipe_ctl_t   ctl,
    input  wire prod_stage_t prod_stage,
    input  wire logic [14:0] drive_limit,
    output enc_out_t         out_item
);

    logic signed [SUM_W-1:0] sum;
    logic signed [8:0]       inc_next;
    logic signed [8:0]       inc_reg;
    logic signed [15:0]      speed4_reg;
    logic signed [15:0]      drive_accum_reg;
    logic signed [15:0]      drive_accum_next;
    logic signed [16:0]      acc_sum;
    logic signed [16:0]      lim;
    logic signed [15:0]      acc_neg;
    enc_out_t                out_reg;
    enc_out_t                out_next;

    always_comb
    begin
        sum = SUM_W'(prod_stage.p_term) + SUM_W'(prod_stage.i_term)
            + SUM_W'(prod_stage.d_term);
        priority if (sum > SUM_W'(STEP_MAX))
        begin
            inc_next = STEP_MAX;
        end
        else if (sum < SUM_W'(STEP_MIN))
        begin
            inc_next = STEP_MIN;
        end
        else
        begin
            inc_next = sum[8:0];
        end
    end

    // The accumulator stays within the limit, so it always fits 16 bits.
    always_comb
    begin
        acc_sum = 17'(drive_accum_reg) + 17'(inc_reg);
        lim     = $signed({2'b00, drive_limit});
        priority if (acc_sum > lim)
        begin
            drive_accum_next = lim[15:0];
        end
        else if (acc_sum < -lim)
        begin
            drive_accum_next = -lim[15:0];
        end
        else
        begin
            drive_accum_next = acc_sum[15:0];
        end
        acc_neg = -drive_accum_next;

        out_next.measured_speed = speed4_reg;
        out_next.duty_forward   = 15'd1;
        out_next.duty_reverse   = 15'd1;
        if (drive_accum_next > 16'sd0)
        begin
            out_next.duty_forward = drive_accum_next[14:0];
        end
        else if (drive_accum_next < 16'sd0)
        begin
            out_next.duty_reverse = acc_neg[14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_accum_reg <= '0;
        end
        else if (ctl.s5_load)
        begin
            drive_accum_reg <= drive_accum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s4_load)
        begin
            inc_reg    <= inc_next;
            speed4_reg <= prod_stage.speed;
        end
        if (ctl.s5_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

    // The accumulator is clamped symmetrically, so the most negative code never appears.
    a_accum_not_min: assert property (@(posedge clk) disable iff (!rst_n)
        drive_accum_reg != SPEED_MIN)
        else $error("drive accumulator reached the most negative code");

endmodule

`default_nettype wire

@@ bench/encpid_speed_checker.sv @@
// Checker for the encoder speed controller: mirrors the register writes, predicts the
// duty and speed result of each tick accepted with control on and compares it with what
// the block returns. Depends on encpid_pkg for the payload types and register indexes.
`timescale 1ns / 1ps

module encpid_speed_checker
    import encpid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  enc_in_t               in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  enc_out_t              out_data,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    results_pending
);

    // Shadow of the register file.
    logic               ctl_on;
    logic signed [15:0] speed_goal;
    logic [15:0]        kp;
    logic [15:0]        ki;
    logic [15:0]        kd;
    logic [14:0]        drive_cap;

    // Shadow of the loop state.
    logic [15:0] prev_count;
    longint      err_last;
    longint      err_older;
    longint      drive_acc;

    enc_out_t speed_loop_results[$];
    int       mismatches = 0;

    function automatic longint clip16(input longint v);
        longint r;
        r = v;
        if (v > 32767)
        begin
            r = 32767;
        end
        else if (v < -32768)
        begin
            r = -32768;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [15:0] delta;
        longint      travel;
        longint      speed;
        longint      err;
        longint      step;
        longint      acc;
        longint      cap;
        enc_out_t    want;

        if (!rst_n)
        begin
            ctl_on     = 1'b0;
            speed_goal = '0;
            kp         = '0;
            ki         = '0;
            kd         = '0;
            drive_cap  = DRIVE_LIMIT_RESET;
            prev_count = '0;
            err_last   = 0;
            err_older  = 0;
            drive_acc  = 0;
            speed_loop_results.delete();
            results_pending <= 0;
            fail_count      <= mismatches;
        end
        else
        begin
            // Results are checked before new requests are queued, so a result can never
            // be matched against a request taken in the same cycle.
            if (out_valid && out_ready)
            begin
                if (speed_loop_results.size() == 0)
                begin
                    $error("unexpected result: duty_forward %0d duty_reverse %0d speed %0d",
                           out_data.duty_forward, out_data.duty_reverse,
                           out_data.measured_speed);
                    mismatches++;
                end
                else
                begin
                    want = speed_loop_results.pop_front();
                    if (out_data.duty_forward !== want.duty_forward)
                    begin
                        $error("duty_forward: expected %0d, got %0d",
                               want.duty_forward, out_data.duty_forward);
                        mismatches++;
                    end
                    if (out_data.duty_reverse !== want.duty_reverse)
                    begin
                        $error("duty_reverse: expected %0d, got %0d",
                               want.duty_reverse, out_data.duty_reverse);
                        mismatches++;
                    end
                    if (out_data.measured_speed !== want.measured_speed)
                    begin
                        $error("measured_speed: expected %0d, got %0d",
                               want.measured_speed, out_data.measured_speed);
                        mismatches++;
                    end
                end
            end

            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_CONTROL_ENABLE: ctl_on     = cfg_wdata[0];
                    CFG_SPEED_SETPOINT: speed_goal = cfg_wdata;
                    CFG_GAIN_PROP:      kp         = cfg_wdata;
                    CFG_GAIN_INTEG:     ki         = cfg_wdata;
                    CFG_GAIN_DERIV:     kd         = cfg_wdata;
                    CFG_DRIVE_LIMIT:    drive_cap  = cfg_wdata[14:0];
                    default:            ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                // The counter change wraps at 16 bits; the pin only gives it a sign.
                delta      = in_data.encoder_count - prev_count;
                prev_count = in_data.encoder_count;
                travel     = longint'(delta);
                speed      = clip16(in_data.moving_forward ? travel : -travel);

                if (ctl_on)
                begin
                    err  = clip16(longint'(speed_goal) - speed);
                    step = longint'(kp) * (err - err_last)
                         + longint'(kd) * (err - 2 * err_last + err_older)
                         + longint'(ki) * err;
                    if (step > 200)
                    begin
                        step = 200;
                    end
                    else if (step < -200)
                    begin
                        step = -200;
                    end

                    cap = longint'(drive_cap);
                    acc = drive_acc + step;
                    if (acc > cap)
                    begin
                        acc = cap;
                    end
                    else if (acc < -cap)
                    begin
                        acc = -cap;
                    end
                    drive_acc = acc;
                    err_older = err_last;
                    err_last  = err;

                    want.duty_forward   = (acc > 0) ? 15'(acc) : 15'd1;
                    want.duty_reverse   = (acc < 0) ? 15'(-acc) : 15'd1;
                    want.measured_speed = 16'(speed);
                    speed_loop_results.push_back(want);
                end
            end

            results_pending <= speed_loop_results.size();
            fail_count      <= mismatches;
        end
    end

endmodule

@@ bench/encoder_incremental_pid_speed_tb.sv @@
// Testbench top for the encoder speed controller: clock, reset, register programming,
// tick requests and output back-pressure. Depends on encpid_pkg, the block and
// encpid_speed_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module encoder_incremental_pid_speed_tb;
    import encpid_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_TICKS = 600;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    enc_in_t               in_data      = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    enc_out_t              out_data;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;

    int fail_count;
    int results_pending;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    encoder_incremental_pid_speed dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    encpid_speed_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("encoder_incremental_pid_speed test failed");
            $finish;
        end
    end

    // Holds the request until it is taken; valid stays high for a following request.
    task automatic send_tick(input logic [15:0] count, input logic fwd);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{encoder_count: count, moving_forward: fwd};
        do @(posedge clk); while (!in_ready);
    endtask

    // Requests taken with control off return nothing and only move the last count; the
    // extra cycles follow the last result before any register changes.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic program_regs(input logic en, input logic signed [15:0] goal,
                                input logic [15:0] gp, input logic [15:0] gi,
                                input logic [15:0] gd, input logic [14:0] lim);
        logic [CFG_DATA_W-1:0] vals [6];
        logic [CFG_IDX_W-1:0]  idxs [6];
        vals = '{{15'd0, en}, goal, gp, gi, gd, {1'b0, lim}};
        idxs = '{CFG_CONTROL_ENABLE, CFG_SPEED_SETPOINT, CFG_GAIN_PROP,
                 CFG_GAIN_INTEG, CFG_GAIN_DERIV, CFG_DRIVE_LIMIT};
        for (int i = 0; i < 6; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= idxs[i];
            cfg_wdata    <= vals[i];
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        logic [15:0]        enc_pos;
        logic               en;
        logic signed [15:0] goal;
        logic [15:0]        gp;
        logic [15:0]        gi;
        logic [15:0]        gd;
        logic [14:0]        lim;
        int                 enabled_ticks;
        int                 seg;
        int                 style;
        int                 seg_len;
        int                 fwd_bias;
        int                 stride;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: control is off, so these requests only move the last count.
        send_tick(16'h1234, 1'b1);
        send_tick(16'h0040, 1'b0);
        wait_for_drain();

        // Speed extremes: zero, forward wrap and saturation, backward exact minimum
        // and saturation.
        program_regs(1'b1, 16'sd100, 16'd3, 16'd1, 16'd2, 15'd2000);
        send_tick(16'h0040, 1'b1);
        send_tick(16'h003f, 1'b1);
        send_tick(16'h803f, 1'b1);
        send_tick(16'h003f, 1'b0);
        send_tick(16'h803e, 1'b0);
        send_tick(16'h003d, 1'b0);
        send_tick(16'h803f, 1'b0);
        send_tick(16'h8040, 1'b1);
        wait_for_drain();

        // Error saturates high; full gains push the accumulator up by the step bound.
        program_regs(1'b1, 16'sh7fff, 16'hffff, 16'hffff, 16'hffff, 15'h7fff);
        send_tick(16'h0040, 1'b0);
        send_tick(16'h8040, 1'b0);
        send_tick(16'h0040, 1'b0);
        send_tick(16'h8040, 1'b0);
        send_tick(16'h0040, 1'b0);
        wait_for_drain();

        // Error saturates low, and the lowered limit clamps the accumulator at once.
        program_regs(1'b1, 16'sh8000, 16'hffff, 16'hffff, 16'hffff, 15'd50);
        send_tick(16'h8040, 1'b1);
        send_tick(16'h0040, 1'b1);
        wait_for_drain();

        // A zero limit holds the accumulator at zero, so both duties idle.
        program_regs(1'b1, 16'sd0, 16'hffff, 16'hffff, 16'hffff, 15'd0);
        send_tick(16'h9000, 1'b1);
        send_tick(16'h9001, 1'b0);
        wait_for_drain();

        // Zero gains leave the drive at zero; counter extremes.
        program_regs(1'b1, 16'sd5, 16'd0, 16'd0, 16'd0, 15'h7fff);
        send_tick(16'hffff, 1'b1);
        send_tick(16'h0000, 1'b0);
        wait_for_drain();

        // Control off holds the error history; turning it back on resumes from it.
        program_regs(1'b0, 16'sd20, 16'd2, 16'd1, 16'd1, 15'd300);
        send_tick(16'h0010, 1'b1);
        send_tick(16'h0030, 1'b1);
        wait_for_drain();
        program_regs(1'b1, 16'sd20, 16'd2, 16'd1, 16'd1, 15'd300);
        send_tick(16'h0040, 1'b1);
        send_tick(16'h0048, 1'b0);
        send_tick(16'h0050, 1'b1);
        wait_for_drain();

        enc_pos       = 16'h0050;
        enabled_ticks = 0;
        seg           = 0;
        while (enabled_ticks < RANDOM_TICKS)
        begin
            style    = $urandom_range(3);
            en       = ($urandom_range(7) != 0);
            fwd_bias = $urandom_range(100);
            stride   = $urandom_range(1, 80);
            goal     = 16'($urandom_range(0, 128) - 64);
            gp       = 16'($urandom_range(3));
            gi       = 16'($urandom_range(3));
            gd       = 16'($urandom_range(3));
            lim      = 15'($urandom_range(1, 3000));
            case (style)
                1:
                begin
                    goal = 16'($urandom);
                    gp   = 16'($urandom);
                    gi   = 16'($urandom);
                    gd   = 16'($urandom);
                    lim  = 15'($urandom);
                end
                2:
                begin
                    goal = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                    gp   = $urandom_range(1) ? 16'hffff : 16'h0000;
                    gi   = $urandom_range(1) ? 16'hffff : 16'h0000;
                    gd   = $urandom_range(1) ? 16'hffff : 16'h0000;
                    lim  = $urandom_range(1) ? 15'h7fff : 15'd1;
                end
                3:
                begin
                    lim = 15'($urandom_range(1, 20));
                end
                default: ;
            endcase
            program_regs(en, goal, gp, gi, gd, lim);

            case (seg % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 69;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 69;
                end
                default:
                begin
                    idle_pct = 34;
                    stall_pct <= 34;
                end
            endcase

            seg_len = en ? 50 : 20;
            for (int k = 0; k < seg_len; k++)
            begin
                if ($urandom_range(15) == 0)
                begin
                    enc_pos = 16'($urandom);
                end
                else
                begin
                    enc_pos = enc_pos + 16'($urandom_range(0, stride));
                end
                send_tick(enc_pos, ($urandom_range(99) < fwd_bias));
            end
            wait_for_drain();
            if (en)
            begin
                enabled_ticks += seg_len;
            end
            seg++;
        end

        if (fail_count == 0)
        begin
            $display("encoder_incremental_pid_speed test passed");
        end
        else
        begin
            $display("encoder_incremental_pid_speed test failed");
        end
        $finish;
    end

endmodule
